// ===== rtl/pbrm_pkg.sv =====
// Package for the packed bitmap row mirror.
// Field widths, count width and the byte bit-reversal helper.
// No dependencies.
package pbrm_pkg;

   localparam int BYTE_W  = 8;   // pixels per packed byte
   localparam int WIDTH_W = 10;  // row width register
   localparam int COUNT_W = 7;   // bytes taken in the current row, 0..127
   localparam int PAD_W   = 3;   // padding bits at the row's end, 0..7

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [WIDTH_W-1:0] width_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [PAD_W-1:0]   pad_type;

   // Bit 0 goes to bit 7 and so on.
   function automatic byte_type flip_byte(input byte_type v);
      byte_type r;
      for (int b = 0; b < BYTE_W; b++) begin
         r[BYTE_W-1-b] = v[b];
      end
      return r;
   endfunction

endpackage

// ===== rtl/packed_bitmap_row_mirror_core.sv =====
// Packed bitmap row mirror, top level: row buffer, read-out pipeline, CSR.
// Depends on pbrm_pkg.
//
// Usage
//  - Input: a pixel byte is taken at a rising edge where start is high and
//    busy is low. Bytes come MSB-first, ceil(width/8) of them per row; the
//    unused low bits of a row's last byte are ignored.
//  - Bytes that do not end a row are taken one per cycle while busy is low and
//    go straight into the row buffer, a single-port synchronous RAM of MAX_ROW_BYTES.
//  - The byte that ends a row raises busy. The buffer is then read back
//    from its end, one entry per cycle, and each read word is bit-reversed
//    and joined with its neighbour to realign the padding to the row's end.
//  - Result words appear on rsp_* for one cycle each, marked by rsp_strobe;
//    rsp_row_end flags the last. The first result follows the row's last
//    byte through the address phase, the data phase and the result register,
//    then one per cycle; busy stays high until the edge that puts out the last.
//    The receiver cannot stall; none is needed.
//  - Config: csr_row_width_pixels is written when csr_valid and csr_ready
//    are high; ready is low while a row is being read out. Width 0 acts as
//    1, widths above MAX_ROW_BYTES*8 saturate.
//  - Reset (synchronous, active high) clears the byte count and pipeline
//    and sets the width to 512. The RAM is not cleared: only entries of
//    the current row are ever used.
module packed_bitmap_row_mirror_core #(
   parameter int MAX_ROW_BYTES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // input word channel
   input  logic                  start,
   output logic                  busy,
   input  pbrm_pkg::byte_type    req_pixel_byte,
   // result word channel
   output logic                  rsp_strobe,
   output pbrm_pkg::byte_type    rsp_mirrored_byte,
   output logic                  rsp_row_end,
   // configuration
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  pbrm_pkg::width_type   csr_row_width_pixels
);
   import pbrm_pkg::*;

   localparam int PTR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
   localparam int MAX_PIXELS = MAX_ROW_BYTES * BYTE_W;

   // ---------------------------------------------------------------
   // Row buffer
   // ---------------------------------------------------------------
   byte_type mem [MAX_ROW_BYTES];

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   width_type        width_ff, width_in;
   count_type        count_ff, count_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic             busy_ff, busy_in;
   logic             issue_ff, issue_in;       // read-out address phase
   count_type        idx_ff, idx_in;
   count_type        nbytes_ff, nbytes_in;
   pad_type          pad_ff, pad_in;
   logic             s1_vld_ff, s1_vld_in;     // read data phase
   logic             s1_first_ff, s1_first_in;
   logic             s1_past_ff, s1_past_in;
   byte_type         rd_data_ff;
   byte_type         hold_ff, hold_in;         // previous flipped word
   logic             rsp_valid_ff, rsp_valid_in;
   byte_type         rsp_byte_ff, rsp_byte_in;
   logic             rsp_end_ff, rsp_end_in;

   // ---------------------------------------------------------------
   // Effective geometry from the live width register
   // ---------------------------------------------------------------
   width_type w_eff;
   count_type nbytes_cur;
   pad_type   pad_cur;
   logic      accept;
   logic      row_done;
   logic [PTR_W-1:0] rd_addr;
   count_type rd_index;
   byte_type  cur_flip;
   logic [3:0] lo_shift;

   always_comb begin
      w_eff = width_ff;
      if (w_eff == '0) begin
         w_eff = width_type'(1);
      end
      if (w_eff > width_type'(MAX_PIXELS)) begin
         w_eff = width_type'(MAX_PIXELS);
      end
      nbytes_cur = count_type'((w_eff + width_type'(7)) >> 3);
      pad_cur    = pad_type'(4'd8 - {1'b0, w_eff[2:0]});
   end

   assign accept   = start && !busy_ff;
   assign row_done = (count_ff + count_type'(1)) >= nbytes_cur;

   // Read back from the row's end: word k comes from entry nbytes-1-k.
   assign rd_index = nbytes_ff - count_type'(1) - idx_ff;
   assign rd_addr  = rd_index[PTR_W-1:0];

   // Past the row's end the word reads as zero.
   assign cur_flip = s1_past_ff ? '0 : flip_byte(rd_data_ff);
   assign lo_shift = 4'd8 - {1'b0, pad_ff};

   always_comb begin
      width_in     = width_ff;
      count_in     = count_ff;
      wp_in        = wp_ff;
      busy_in      = busy_ff;
      issue_in     = issue_ff;
      idx_in       = idx_ff;
      nbytes_in    = nbytes_ff;
      pad_in       = pad_ff;
      s1_vld_in    = 1'b0;
      s1_first_in  = s1_first_ff;
      s1_past_in   = s1_past_ff;
      hold_in      = hold_ff;
      rsp_valid_in = 1'b0;
      rsp_byte_in  = rsp_byte_ff;
      rsp_end_in   = 1'b0;

      if (csr_valid && csr_ready) begin
         width_in = csr_row_width_pixels;
      end

      // Input side: count the byte; the row's last one starts read-out.
      if (accept) begin
         if (row_done) begin
            count_in  = '0;
            wp_in     = '0;
            busy_in   = 1'b1;
            issue_in  = 1'b1;
            idx_in    = '0;
            nbytes_in = nbytes_cur;
            pad_in    = pad_cur;
         end else begin
            count_in = count_ff + count_type'(1);
            wp_in    = (wp_ff == PTR_W'(MAX_ROW_BYTES - 1)) ? '0 : wp_ff + PTR_W'(1);
         end
      end

      // Address phase: nbytes reads, then one slot for the zero past the end.
      if (issue_ff) begin
         s1_vld_in   = 1'b1;
         s1_first_in = (idx_ff == '0);
         s1_past_in  = (idx_ff == nbytes_ff);
         idx_in      = idx_ff + count_type'(1);
         if (idx_ff == nbytes_ff) begin
            issue_in = 1'b0;
         end
      end

      // Data phase: join the held word with the next one, shifted by pad.
      if (s1_vld_ff) begin
         hold_in = cur_flip;
         if (!s1_first_ff) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = byte_type'(hold_ff << pad_ff) | byte_type'(cur_flip >> lo_shift);
            rsp_end_in   = s1_past_ff;
         end
         if (s1_past_ff) begin
            busy_in = 1'b0;
         end
      end
   end

   // Row buffer: write on every accepted byte, read during address phase.
   always_ff @(posedge clock) begin
      if (accept) begin
         mem[wp_ff] <= req_pixel_byte;
      end
      if (issue_ff) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= width_type'(512);
         count_ff     <= '0;
         wp_ff        <= '0;
         busy_ff      <= 1'b0;
         issue_ff     <= 1'b0;
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_end_ff   <= 1'b0;
      end else begin
         width_ff     <= width_in;
         count_ff     <= count_in;
         wp_ff        <= wp_in;
         busy_ff      <= busy_in;
         issue_ff     <= issue_in;
         s1_vld_ff    <= s1_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_end_ff   <= rsp_end_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      nbytes_ff   <= nbytes_in;
      pad_ff      <= pad_in;
      s1_first_ff <= s1_first_in;
      s1_past_ff  <= s1_past_in;
      hold_ff     <= hold_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign busy              = busy_ff;
   assign csr_ready         = !busy_ff;
   assign rsp_strobe        = rsp_valid_ff;
   assign rsp_mirrored_byte = rsp_byte_ff;
   assign rsp_row_end       = rsp_end_ff;

`ifndef SYNTHESIS
   // Results only come out of a read-out that held busy.
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy_ff))
      else $error("result word without a read-out in progress");

   // The last word of a row releases busy on the same edge.
   a_end_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_row_end) |-> !busy_ff)
      else $error("busy still high after row end");

   // Words before the row's end keep busy high.
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_row_end) |-> busy_ff)
      else $error("busy dropped mid-row");

   // Address phase only runs inside busy.
   a_issue_busy: assert property (@(posedge clock) disable iff (reset)
      issue_ff |-> busy_ff)
      else $error("buffer read issued while idle");

   // Byte count never passes the buffer depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(MAX_ROW_BYTES))
      else $error("byte count beyond row buffer");
`endif

endmodule
